### src/gpfd_pkg.sv
package gpfd_pkg;

   // protocol constants of the poll reply
   localparam logic [7:0] READY_MARK = 8'h5A;
   localparam logic [7:0] ID_DIGITAL = 8'h41;
   localparam logic [7:0] ID_ANALOG  = 8'h73;
   localparam logic [7:0] STICK_FLIP = 8'h80;

   // axis values for a digital pad
   localparam logic signed [7:0] AXIS_POS  = 8'sh7F;
   localparam logic signed [7:0] AXIS_NEG  = 8'sh81;
   localparam logic signed [7:0] AXIS_ZERO = 8'sh00;

   localparam logic [6:0] DEAD_ZONE_RESET = 7'd5;

   // frame position codes
   localparam int unsigned STORE_DEPTH = 8;
   localparam logic [3:0]  POS_LAST = 4'd8;
   localparam logic [3:0]  POS_IDLE = 4'd9;

   // pad mode codes
   localparam logic [1:0] MODE_DIGITAL = 2'd0;
   localparam logic [1:0] MODE_ANALOG  = 2'd1;
   localparam logic [1:0] MODE_OTHER   = 2'd2;

   // button bits that only follow the pad in analog mode (stick clicks)
   localparam logic [15:0] CLICK_MASK = 16'h0006;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_start;
   } req_word_type;

   typedef struct packed {
      logic [15:0]       buttons;
      logic signed [7:0] left_x;
      logic signed [7:0] left_y;
      logic signed [7:0] right_x;
      logic signed [7:0] right_y;
      logic [1:0]        pad_mode;
   } rsp_word_type;

   typedef struct packed {
      logic         valid;
      req_word_type word;
   } stage_type;

endpackage

### src/gpfd_in_stage.sv
module gpfd_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  gpfd_pkg::req_word_type req_word,
   output gpfd_pkg::stage_type   stage,
   input  logic                  stage_take
);
   import gpfd_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_word_type word_ff;
   req_word_type word_in;

   // register frees up in the same cycle its word is taken
   assign req_ready = !valid_ff || stage_take;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (req_ready) begin
         valid_in = req_valid;
         word_in  = req_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign stage.valid = valid_ff;
   assign stage.word  = word_ff;

endmodule

### src/gpfd_decode.sv
module gpfd_decode (
   input  logic                  clock,
   input  logic                  reset,
   input  gpfd_pkg::stage_type   stage,
   output logic                  stage_take,
   input  logic [6:0]            dead_zone,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output gpfd_pkg::rsp_word_type rsp_word
);
   import gpfd_pkg::*;

   function automatic logic signed [7:0] digital_axis(input logic pos_bit, input logic neg_bit);
      logic signed [7:0] v;
      v = AXIS_ZERO;
      if (pos_bit && !neg_bit) begin
         v = AXIS_POS;
      end else if (neg_bit && !pos_bit) begin
         v = AXIS_NEG;
      end
      return v;
   endfunction

   // magnitude up to 128 compared without saturation
   function automatic logic signed [7:0] apply_dead_zone(input logic signed [7:0] v,
                                                          input logic [6:0] dz);
      logic [7:0]        mag;
      logic signed [7:0] r;
      mag = v[7] ? (8'd0 - 8'(v)) : 8'(v);
      r   = (mag < {1'b0, dz}) ? AXIS_ZERO : v;
      return r;
   endfunction

   logic [7:0]        store_ff [STORE_DEPTH];
   logic [3:0]        pos_ff;
   logic [3:0]        pos_in;
   logic [3:0]        pos_cur;
   logic [15:0]       buttons_ff;
   logic [15:0]       buttons_in;
   logic signed [7:0] axes_ff [4];
   logic signed [7:0] axes_in [4];
   logic signed [7:0] axes_raw [4];
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   rsp_word_type      rsp_word_ff;
   rsp_word_type      rsp_word_in;
   logic              emit;
   logic              out_free;
   logic              store_we;
   logic [7:0]        p3;
   logic [7:0]        p4;
   logic [1:0]        mode;

   always_comb begin
      pos_cur  = stage.word.frame_start ? 4'd0 : pos_ff;
      emit     = (pos_cur == POS_LAST) && (store_ff[2] == READY_MARK);
      out_free = !rsp_valid_ff || rsp_ready;
      stage_take = stage.valid && (!emit || out_free);
      store_we = stage_take && (pos_cur < POS_LAST);

      pos_in = pos_ff;
      if (stage_take) begin
         if (pos_cur < POS_LAST) begin
            pos_in = pos_cur + 4'd1;
         end else begin
            pos_in = POS_IDLE;
         end
      end
   end

   // decode of a finished frame, byte 8 is the word in the stage
   always_comb begin
      p3 = ~store_ff[3];
      p4 = ~store_ff[4];
      buttons_in = (buttons_ff & CLICK_MASK) | {p4, p3 & ~CLICK_MASK[7:0]};
      for (int k = 0; k < 4; k++) begin
         axes_raw[k] = axes_ff[k];
      end
      mode = MODE_OTHER;
      if (store_ff[1] == ID_DIGITAL) begin
         mode        = MODE_DIGITAL;
         axes_raw[0] = digital_axis(p3[5], p3[7]);
         axes_raw[1] = digital_axis(p3[4], p3[6]);
         axes_raw[2] = digital_axis(p4[5], p4[7]);
         axes_raw[3] = digital_axis(p4[4], p4[6]);
      end else if (store_ff[1] == ID_ANALOG) begin
         mode        = MODE_ANALOG;
         buttons_in  = (buttons_in & ~CLICK_MASK) | ({8'd0, p3} & CLICK_MASK);
         axes_raw[0] = store_ff[7] ^ STICK_FLIP;
         axes_raw[1] = ~stage.word.rx_byte ^ STICK_FLIP;
         axes_raw[2] = store_ff[5] ^ STICK_FLIP;
         axes_raw[3] = ~store_ff[6] ^ STICK_FLIP;
      end
      for (int k = 0; k < 4; k++) begin
         axes_in[k] = apply_dead_zone(axes_raw[k], dead_zone);
      end

      rsp_word_in.buttons  = buttons_in;
      rsp_word_in.left_x   = axes_in[0];
      rsp_word_in.left_y   = axes_in[1];
      rsp_word_in.right_x  = axes_in[2];
      rsp_word_in.right_y  = axes_in[3];
      rsp_word_in.pad_mode = mode;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (stage_take && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_IDLE;
         buttons_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 4; k++) begin
            axes_ff[k] <= AXIS_ZERO;
         end
      end else begin
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
         if (stage_take && emit) begin
            buttons_ff <= buttons_in;
            for (int k = 0; k < 4; k++) begin
               axes_ff[k] <= axes_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[pos_cur[2:0]] <= stage.word.rx_byte;
      end
      if (stage_take && emit) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

### src/gamepad_poll_frame_decoder_unit.sv
// gamepad poll reply decoder: takes the nine bytes of a poll reply one word at a
// time (frame_start marks byte 0, and always restarts the frame) and, after the
// ninth byte, returns one word with sixteen active-high buttons, four signed stick
// axes and the pad mode, but only when byte 2 is the 0x5a ready marker. digital
// pads give axes of -127, 0 or +127 from the direction buttons; analog pads give
// centered stick bytes with y up positive and also refresh the two stick clicks;
// any other id keeps the last axes and clicks. axes whose magnitude is below the
// dead zone register (reset 5) read as zero. one byte is accepted every cycle:
// a byte goes through an input register and then one decode step into the
// result register. only a ninth byte of a ready frame that meets a result
// still waiting on rsp_ready holds the byte channel off, for as long as that
// result waits. the user must write the dead zone register through the csr
// channel only while the block is idle; the block does not enforce this.
module gamepad_poll_frame_decoder_unit (
   input  logic                   clock,
   input  logic                   reset,
   // byte channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  gpfd_pkg::req_word_type  req_word,
   // decoded result channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output gpfd_pkg::rsp_word_type  rsp_word,
   // dead zone register write
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [6:0]             csr_dead_zone
);
   import gpfd_pkg::*;

   stage_type  stage;
   logic       stage_take;
   logic [6:0] dead_zone_ff;
   logic [6:0] dead_zone_in;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      dead_zone_in = dead_zone_ff;
      if (csr_valid) begin
         dead_zone_in = csr_dead_zone;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff <= DEAD_ZONE_RESET;
      end else begin
         dead_zone_ff <= dead_zone_in;
      end
   end

   // input register, parts the byte channel from the decode
   gpfd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .stage      (stage),
      .stage_take (stage_take)
   );

   // frame store, held state and result register
   gpfd_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .stage      (stage),
      .stage_take (stage_take),
      .dead_zone  (dead_zone_ff),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word)
   );

   // a new result only comes from a byte that sat in the input register
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(stage.valid))
      else $error("result appeared with no byte in the input register");

   // a digital pad only gives full-scale or zero axes
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.pad_mode == MODE_DIGITAL) |->
         ((rsp_word.left_x == AXIS_POS || rsp_word.left_x == AXIS_NEG ||
           rsp_word.left_x == AXIS_ZERO) &&
          (rsp_word.right_y == AXIS_POS || rsp_word.right_y == AXIS_NEG ||
           rsp_word.right_y == AXIS_ZERO)))
      else $error("digital pad gave a partial axis value");

   // an empty input register never holds off the byte channel
   assert property (@(posedge clock) disable iff (reset)
      !stage.valid |-> req_ready)
      else $error("byte channel stalled with an empty input register");

endmodule

### bench/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gpfd_pkg::*;

   // decode predictor plus the queue of decoded words still owed by the block
   class poll_decode_scoreboard;
      logic [7:0]    frame_bytes [STORE_DEPTH];
      logic [3:0]    next_pos;
      logic [15:0]   button_state;
      logic [7:0]    axis_state [4];
      logic [6:0]    zone_limit;
      rsp_word_type  expected_words [$];
      int            failures;
      int            checked;

      function new();
         foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
         foreach (axis_state[i]) axis_state[i] = AXIS_ZERO;
         next_pos     = POS_IDLE;
         button_state = 16'h0000;
         zone_limit   = DEAD_ZONE_RESET;
         failures     = 0;
         checked      = 0;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      function void note_failure(string msg);
         failures++;
         if (failures <= 10)
            $display("%s", msg);
      endfunction

      // -127, 0 or +127 from a pair of opposing pad buttons (active high)
      function logic [7:0] pad_axis(logic toward, logic away);
         case ({toward, away})
            2'b10: return AXIS_POS;
            2'b01: return AXIS_NEG;
            default: return AXIS_ZERO;
         endcase
      endfunction

      // returns 1 when the byte belongs to a frame, 0 when the block ignores it
      function bit note_byte(req_word_type w);
         logic [7:0]   id;
         logic [7:0]   p3;
         logic [7:0]   p4;
         logic [1:0]   mode;
         rsp_word_type r;
         int           v;
         int           k;
         if (w.frame_start)
            next_pos = 4'd0;
         if (next_pos > POS_LAST)
            return 1'b0;
         if (next_pos != POS_LAST) begin
            frame_bytes[next_pos[2:0]] = w.rx_byte;
            next_pos = next_pos + 4'd1;
            return 1'b1;
         end
         next_pos = POS_IDLE;
         if (frame_bytes[2] != READY_MARK)
            return 1'b1;

         id = frame_bytes[1];
         p3 = ~frame_bytes[3];
         p4 = ~frame_bytes[4];
         button_state = (button_state & CLICK_MASK) | {p4, p3 & ~CLICK_MASK[7:0]};

         if (id == ID_DIGITAL) begin
            mode = MODE_DIGITAL;
            axis_state[0] = pad_axis(p3[5], p3[7]);
            axis_state[1] = pad_axis(p3[4], p3[6]);
            axis_state[2] = pad_axis(p4[5], p4[7]);
            axis_state[3] = pad_axis(p4[4], p4[6]);
         end else if (id == ID_ANALOG) begin
            mode = MODE_ANALOG;
            button_state[2:1] = p3[2:1];
            axis_state[0] = frame_bytes[7] - STICK_FLIP;
            axis_state[1] = AXIS_POS - w.rx_byte;
            axis_state[2] = frame_bytes[5] - STICK_FLIP;
            axis_state[3] = AXIS_POS - frame_bytes[6];
         end else begin
            mode = MODE_OTHER;
         end

         // dead zone on the held axes, full-scale -128 included
         for (k = 0; k < 4; k++) begin
            v = $signed(axis_state[k]);
            if (v < 0)
               v = -v;
            if (v < int'(zone_limit))
               axis_state[k] = AXIS_ZERO;
         end

         r.buttons  = button_state;
         r.left_x   = axis_state[0];
         r.left_y   = axis_state[1];
         r.right_x  = axis_state[2];
         r.right_y  = axis_state[3];
         r.pad_mode = mode;
         expected_words.push_back(r);
         return 1'b1;
      endfunction

      function void check_word(rsp_word_type got);
         rsp_word_type want;
         string        bad;
         if (expected_words.size() == 0) begin
            note_failure($sformatf("decoded word with none expected: btn %h mode %0d",
                                   got.buttons, got.pad_mode));
            return;
         end
         want = expected_words.pop_front();
         checked++;
         bad = "";
         if (got.buttons !== want.buttons) bad = {bad, " buttons"};
         if (got.left_x !== want.left_x) bad = {bad, " left_x"};
         if (got.left_y !== want.left_y) bad = {bad, " left_y"};
         if (got.right_x !== want.right_x) bad = {bad, " right_x"};
         if (got.right_y !== want.right_y) bad = {bad, " right_y"};
         if (got.pad_mode !== want.pad_mode) bad = {bad, " pad_mode"};
         if (bad != "")
            note_failure($sformatf(
               "word %0d wrong in%s: expected %h %0d %0d %0d %0d %0d, got %h %0d %0d %0d %0d %0d",
               checked, bad,
               want.buttons, want.left_x, want.left_y, want.right_x, want.right_y,
               want.pad_mode,
               got.buttons, got.left_x, got.left_y, got.right_x, got.right_y,
               got.pad_mode));
      endfunction

      function void flush_leftover();
         while (expected_words.size() != 0) begin
            note_failure($sformatf("decoded word never arrived: btn %h",
                                   expected_words[0].buttons));
            void'(expected_words.pop_front());
         end
      endfunction
   endclass

   localparam int BYTES_PER_PHASE = 240;
   localparam int SETTLE_CYCLES   = 8;

   typedef enum int {RX_STEADY, RX_RANDOM, RX_PERIODIC} rx_style_e;

   logic         clock;
   logic         reset         = 1'b1;
   logic         req_valid     = 1'b0;
   logic         req_ready;
   req_word_type req_word      = '0;
   logic         rsp_valid;
   logic         rsp_ready     = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_valid     = 1'b0;
   logic         csr_ready;
   logic [6:0]   csr_dead_zone = 7'd0;

   poll_decode_scoreboard board = new();

   // sender burst state and run statistics
   int        burst_left     = 0;
   int        taken_bytes    = 0;
   int        ignored_bytes  = 0;
   int        zone_settings  = 1;
   rx_style_e rx_style       = RX_STEADY;
   int        rx_style_left  = 0;
   int        rx_tick        = 0;

   gamepad_poll_frame_decoder_unit DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_word      (rsp_word),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_dead_zone (csr_dead_zone)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // receiver: each stretch picks its own stall style, steady ready included
   always @(negedge clock) begin
      if (rx_style_left == 0) begin
         rx_style      = rx_style_e'($urandom_range(0, 2));
         rx_style_left = $urandom_range(64, 256);
      end
      rx_style_left--;
      rx_tick++;
      case (rx_style)
         RX_STEADY: rsp_ready <= 1'b1;
         RX_RANDOM: rsp_ready <= ($urandom_range(0, 2) != 0);
         default: rsp_ready <= ((rx_tick % 8) < 3);
      endcase
   end

   // every accepted decoded word goes straight to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_word(rsp_word);
   end

   // bursts of back-to-back words, with random gaps and the odd long burst
   function automatic int next_gap();
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
      return $urandom_range(1, 6);
   endfunction

   // entered and left at a falling edge; valid stays up between back-to-back words
   task automatic send_byte(input logic [7:0] value, input logic first);
      int gap;
      gap = next_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= '{rx_byte: value, frame_start: first};
      do @(posedge clock); while (!req_ready);
      if (board.note_byte(req_word))
         taken_bytes++;
      else
         ignored_bytes++;
      @(negedge clock);
   endtask

   // hold off the byte channel until every owed decoded word has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic write_dead_zone(input logic [6:0] value);
      wait_drained();
      // a frame that ends not ready leaves no word to wait for, so let it settle
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid     <= 1'b1;
      csr_dead_zone <= value;
      do @(posedge clock); while (!csr_ready);
      board.zone_limit = value;
      zone_settings++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_frame(input logic [7:0] b0, input logic [7:0] b1,
                             input logic [7:0] b2, input logic [7:0] b3,
                             input logic [7:0] b4, input logic [7:0] b5,
                             input logic [7:0] b6, input logic [7:0] b7,
                             input logic [7:0] b8);
      send_byte(b0, 1'b1);
      send_byte(b1, 1'b0);
      send_byte(b2, 1'b0);
      send_byte(b3, 1'b0);
      send_byte(b4, 1'b0);
      send_byte(b5, 1'b0);
      send_byte(b6, 1'b0);
      send_byte(b7, 1'b0);
      send_byte(b8, 1'b0);
   endtask

   // mostly well-formed replies with random content, some cut short or not ready
   task automatic send_random_frame();
      logic [7:0] frame [9];
      int         pick;
      int         length;
      int         k;
      pick = $urandom_range(0, 99);
      for (k = 0; k < 9; k++)
         frame[k] = 8'($urandom);
      if (pick < 40)
         frame[1] = ID_DIGITAL;
      else if (pick < 80)
         frame[1] = ID_ANALOG;
      if ($urandom_range(0, 9) != 0)
         frame[2] = READY_MARK;
      // sticks near center land on both sides of the dead zone
      for (k = 5; k < 9; k++)
         if ($urandom_range(0, 2) == 0)
            frame[k] = STICK_FLIP + 8'($urandom_range(0, 31)) - 8'd16;
      length = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 8) : 9;
      for (k = 0; k < length; k++)
         send_byte(frame[k], k == 0);
      // stray bytes: ignored after a whole frame, swallowed after a cut one
      if ($urandom_range(0, 9) == 0)
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
      if ($urandom_range(0, 29) == 0)
         wait_drained();
   endtask

   task automatic run_random_phase();
      int goal;
      goal = taken_bytes + BYTES_PER_PHASE;
      while (taken_bytes < goal)
         send_random_frame();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // stray byte while idle, then a frame restarted after its first byte
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      // analog, byte 3 buttons pressed, byte 4 buttons released, sticks at full scale, left y inside dead zone
      send_frame(8'h00, ID_ANALOG, READY_MARK, 8'h00, 8'hFF,
                 8'h00, 8'h00, 8'hFF, 8'h80);
      // unknown id: axes and stick clicks held, dead zone applied again
      send_frame(8'hFF, 8'h00, READY_MARK, 8'hFF, 8'h00,
                 8'h55, 8'hAA, 8'h01, 8'hFE);
      // digital frame without the ready marker gives no word
      send_frame(8'h01, ID_DIGITAL, 8'hA5, 8'h0F, 8'hF0,
                 8'h12, 8'h34, 8'h56, 8'h78);

      run_random_phase();
      write_dead_zone(7'd0);
      run_random_phase();
      write_dead_zone(7'd127);
      run_random_phase();
      write_dead_zone(7'($urandom_range(1, 126)));
      run_random_phase();
      write_dead_zone(7'($urandom_range(2, 40)));
      run_random_phase();

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      board.flush_leftover();

      $display("covered %0d frame bytes and %0d ignored idle bytes", taken_bytes,
               ignored_bytes);
      $display("%0d decoded words compared across %0d dead zone settings", board.checked,
               zone_settings);
      if (board.failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // hard stop far beyond the slowest legal run
   initial begin
      #2000000;
      $display("timeout with %0d decoded words outstanding", board.pending());
      $display("simulation failed");
      $finish;
   end

endmodule
